FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file sh256_chk.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/sh256_pkg.sv
// Shabal-256 package: initial vectors, controller types, command/status structs.
// No dependencies.
package sh256_pkg;

  localparam logic [31:0] A_INIT [12] = '{
    32'h52F84552, 32'hE54B7999, 32'h2D8EE3EC, 32'hB9645191,
    32'hE0078B86, 32'hBB7C44C9, 32'hD2B5C1CA, 32'hB0D2EB8C,
    32'h14CE5A45, 32'h22AF50DC, 32'hEFFDBC6B, 32'hEB21B74A};
  localparam logic [31:0] B_INIT [16] = '{
    32'hB555C6EE, 32'h3E710596, 32'hA72A652F, 32'h9301515F,
    32'hDA28C1FA, 32'h696FD868, 32'h9CB6BF72, 32'h0AFE4002,
    32'hA6E03615, 32'h5138C1D4, 32'hBE216306, 32'hB38B8890,
    32'h3EA8B96B, 32'h3299ACE4, 32'h30924DD4, 32'h55CB34A5};
  localparam logic [31:0] C_INIT [16] = '{
    32'hB405F031, 32'hC4233EBA, 32'hB3733979, 32'hC0DD9D55,
    32'hC51C28AE, 32'hA327B8E1, 32'h56C56167, 32'hED614433,
    32'h88B59D60, 32'h60E2CEBA, 32'h758B4B8B, 32'h83E82A7F,
    32'hBC968828, 32'hE6E00BF7, 32'hBA839E55, 32'h9B491C60};

  localparam int unsigned NSTEP = 48;

  typedef enum logic [3:0] {
    ST_LOAD,    // collecting message words
    ST_PRE,     // B += M, A ^= W, rotate B
    ST_STEP,    // one permutation step per cycle
    ST_ADDC,    // A += C words
    ST_FIN,     // ordinary block: C -= M, swap, W++
    ST_TSWAP,   // final rounds: swap, A ^= W, rotate B
    ST_OUT,     // present digest words
    ST_INIT     // back to initial vectors
  } sh_state_t;

  typedef struct packed {
    logic load;     // store message word
    logic pre;
    logic step;
    logic addc;
    logic fin;
    logic tswap;
    logic init;
  } sh_cmd_t;

  typedef struct packed {
    logic [5:0] step_idx;
  } sh_sts_t;

endpackage

FILE: hw/rtl/sh256_dp.sv
// Shabal-256 datapath: A/B/C state, counter, message memory, one step per cycle.
// Depends on sh256_pkg.
module sh256_dp import sh256_pkg::*; (
  input  logic        clk,
  input  sh_cmd_t     cmd,
  input  logic [3:0]  wpos,
  input  logic [5:0]  step,
  input  logic [2:0]  oidx,
  input  logic [31:0] in_word,
  output logic [31:0] dig
);
  logic [31:0] a_r [12];
  logic [31:0] b_r [16];
  logic [31:0] c_r [16];
  logic [31:0] m_r [16];
  logic [63:0] w_r;

  logic [3:0] ai, ap, bi, b1, b2, b3, ci;
  logic [31:0] t, x, xn;
  logic [5:0] s12;

  always_comb begin
    s12 = (step >= 6'd36) ? step - 6'd36 : (step >= 6'd24) ? step - 6'd24 :
          (step >= 6'd12) ? step - 6'd12 : step;
    ai = s12[3:0];
    ap = (ai == 4'd0) ? 4'd11 : ai - 4'd1;
    bi = step[3:0];
    b1 = step[3:0] + 4'd13;
    b2 = step[3:0] + 4'd9;
    b3 = step[3:0] + 4'd6;
    ci = 4'd8 - step[3:0];
    t  = {a_r[ap][16:0], a_r[ap][31:17]} * 32'd5;
    xn = (a_r[ai] ^ t ^ c_r[ci]) * 32'd3;
    x  = xn ^ b_r[b1] ^ (b_r[b2] & ~b_r[b3]) ^ m_r[bi];
  end

  assign dig = b_r[{1'b1, oidx}];

  always_ff @(posedge clk) begin
    if (cmd.load) m_r[wpos] <= in_word;
    if (cmd.init) begin
      for (int i = 0; i < 12; i++) a_r[i] <= A_INIT[i];
      for (int i = 0; i < 16; i++) begin
        b_r[i] <= B_INIT[i];
        c_r[i] <= C_INIT[i];
      end
      w_r <= 64'd1;
    end else if (cmd.pre || cmd.tswap) begin
      a_r[0] <= a_r[0] ^ w_r[31:0];
      a_r[1] <= a_r[1] ^ w_r[63:32];
      for (int i = 0; i < 16; i++) begin
        logic [31:0] bv;
        bv = cmd.pre ? b_r[i] + m_r[i] : c_r[i];
        b_r[i] <= {bv[14:0], bv[31:15]};
        if (cmd.tswap) c_r[i] <= b_r[i];
      end
    end else if (cmd.step) begin
      a_r[ai] <= x;
      b_r[bi] <= ~({b_r[bi][30:0], b_r[bi][31]} ^ x);
    end else if (cmd.addc) begin
      for (int i = 0; i < 12; i++)
        a_r[i] <= a_r[i] + c_r[(i + 3) % 16] + c_r[(i + 15) % 16] + c_r[(i + 27) % 16];
    end else if (cmd.fin) begin
      for (int i = 0; i < 16; i++) begin
        b_r[i] <= c_r[i] - m_r[i];
        c_r[i] <= b_r[i];
      end
      w_r <= w_r + 64'd1;
    end
  end
endmodule

FILE: hw/rtl/sh256_ctrl.sv
// Shabal-256 controller: block sequencing and output handshake.
// Depends on sh256_pkg.
module sh256_ctrl import sh256_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_mode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output sh_cmd_t    cmd,
  output logic [3:0] wpos,
  output logic [5:0] step,
  output logic [2:0] oidx
);
  sh_state_t st_r, st_nxt;
  logic [3:0] wpos_r, wpos_nxt;
  logic [5:0] step_r, step_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic [1:0] rnd_r, rnd_nxt;
  logic       fin_r, fin_nxt;
  logic       acc;

  assign acc  = in_valid && !in_stall;
  assign wpos = wpos_r;
  assign step = step_r;
  assign oidx = oidx_r;

  always_comb begin
    st_nxt = st_r; wpos_nxt = wpos_r; step_nxt = step_r;
    oidx_nxt = oidx_r; rnd_nxt = rnd_r; fin_nxt = fin_r;
    case (st_r)
      ST_LOAD: if (acc) begin
        wpos_nxt = wpos_r + 4'd1;
        if (wpos_r == 4'd15) begin
          st_nxt = ST_PRE; fin_nxt = in_mode; rnd_nxt = 2'd0;
        end
      end
      ST_PRE, ST_TSWAP: begin st_nxt = ST_STEP; step_nxt = 6'd0; end
      ST_STEP: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(NSTEP - 1)) st_nxt = ST_ADDC;
      end
      ST_ADDC:
        if (!fin_r) st_nxt = ST_FIN;
        else if (rnd_r == 2'd3) begin st_nxt = ST_OUT; oidx_nxt = 3'd0; end
        else begin st_nxt = ST_TSWAP; rnd_nxt = rnd_r + 2'd1; end
      ST_FIN:  st_nxt = ST_LOAD;
      ST_OUT: if (!out_stall) begin
        oidx_nxt = oidx_r + 3'd1;
        if (oidx_r == 3'd7) st_nxt = ST_INIT;
      end
      ST_INIT: st_nxt = ST_LOAD;
      default: st_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (st_r)
      ST_LOAD:  begin in_stall = 1'b0; cmd.load = in_valid; end
      ST_PRE:   cmd.pre = 1'b1;
      ST_STEP:  cmd.step = 1'b1;
      ST_ADDC:  cmd.addc = 1'b1;
      ST_FIN:   cmd.fin = 1'b1;
      ST_TSWAP: cmd.tswap = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      ST_INIT:  cmd.init = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_INIT; wpos_r <= '0; step_r <= '0;
      oidx_r <= '0; rnd_r <= '0; fin_r <= 1'b0;
    end else begin
      st_r <= st_nxt; wpos_r <= wpos_nxt; step_r <= step_nxt;
      oidx_r <= oidx_nxt; rnd_r <= rnd_nxt; fin_r <= fin_nxt;
    end
  end
endmodule

FILE: hw/rtl/shabal256_hash_core.sv
// Shabal-256 hash core for one message stream.
// Depends on sh256_pkg, sh256_ctrl, sh256_dp.
//
// Usage:
//  - Input channel: one 32-bit message word per transfer (in_message_word),
//    little-endian bytes, 16 words per block. in_mode of the 16th word picks
//    an ordinary block (0) or the already padded final block (1).
//  - Words 1..15 of a block are taken one per cycle. The 16th word starts the
//    absorb, with in_stall high throughout: a setup step, 48 permutation steps
//    (one per cycle, a single step unit), an add and a finish; only then is
//    the first word of the next block taken.
//  - A final block runs four permutations, then presents eight digest words
//    B[8..15] on the output channel, word_index 0..7, last_word on the eighth.
//    Each word is held while out_stall is high.
//  - After the last digest word, an init state reloads the initial vectors.
//  - Reset (rst_n low, synchronous) takes one cycle after release to load
//    the initial vectors; in_stall is high during it.
module shabal256_hash_core import sh256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_message_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sh_cmd_t    cmd;
  logic [3:0] wpos;
  logic [5:0] step;
  logic [2:0] oidx;

  sh256_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_mode, .in_stall, .out_valid, .out_stall,
    .cmd, .wpos, .step, .oidx
  );

  sh256_dp u_dp (
    .clk, .cmd, .wpos, .step, .oidx, .in_word(in_message_word),
    .dig(out_digest_word)
  );

  // Digest words come straight from the held B state.
  assign out_word_index = oidx;
  assign out_last_word  = (oidx == 3'd7);
endmodule

FILE: hw/rtl/sh256_chk.sv
// Port-level checker for shabal256_hash_core, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sh256_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_word_index,
  input logic       out_last_word
);
  `CHK_IMPLY(a_no_in_out, clk, rst_n, out_valid, in_stall, "input open while emitting")
  `CHK_IMPLY(a_last, clk, rst_n, out_valid, out_last_word == (out_word_index == 3'd7), "last flag")
  `CHK_NEXT(a_adv, clk, rst_n, out_valid && !out_stall && !out_last_word, out_valid && out_word_index == $past(out_word_index) + 3'd1, "index skip")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word_index), "stalled word moved")
endmodule

bind shabal256_hash_core sh256_chk u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_word_index, .out_last_word
);

FILE: test/tb_top.sv
// Testbench for shabal256_hash_core: directed blocks and random message streams checked
// word by word against a Shabal-256 predictor held in a scoreboard class. Depends on sh256_pkg.
module tb_top;
  import sh256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  // Predictor of the hash core: its own copy of the chaining state, plus the
  // queue of digest words still owed by the block.
  class digest_scoreboard;
    logic [31:0] a_reg [12];
    logic [31:0] b_reg [16];
    logic [31:0] c_reg [16];
    logic [31:0] msg_blk [16];
    logic [63:0] blk_cnt;
    int unsigned fill;
    logic [31:0] dig_q [$];
    logic [2:0]  idx_q [$];
    logic        last_q [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      init_state();
    endfunction

    function void init_state();
      for (int i = 0; i < 12; i++) a_reg[i] = A_INIT[i];
      for (int i = 0; i < 16; i++) begin
        b_reg[i] = B_INIT[i];
        c_reg[i] = C_INIT[i];
      end
      blk_cnt = 64'd1;
      fill = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void mix_counter();
      a_reg[0] ^= blk_cnt[31:0];
      a_reg[1] ^= blk_cnt[63:32];
    endfunction

    function void exchange_bc();
      logic [31:0] t;
      for (int i = 0; i < 16; i++) begin
        t = b_reg[i];
        b_reg[i] = c_reg[i];
        c_reg[i] = t;
      end
    endfunction

    function void permute();
      int ai, ap, bi, b1, b2, b3, ci;
      logic [31:0] t, x;
      for (int i = 0; i < 16; i++) b_reg[i] = rol(b_reg[i], 17);
      for (int j = 0; j < 48; j++) begin
        ai = j % 12; ap = (j + 11) % 12;
        bi = j & 15; b1 = (j + 13) & 15; b2 = (j + 9) & 15; b3 = (j + 6) & 15;
        ci = (56 - j) & 15;
        t = rol(a_reg[ap], 15) * 32'd5;
        x = (a_reg[ai] ^ t ^ c_reg[ci]) * 32'd3;
        x ^= b_reg[b1] ^ (b_reg[b2] & ~b_reg[b3]) ^ msg_blk[bi];
        a_reg[ai] = x;
        b_reg[bi] = ~(rol(b_reg[bi], 1) ^ x);
      end
      for (int i = 0; i < 12; i++)
        a_reg[i] = a_reg[i] + c_reg[(i + 3) & 15] + c_reg[(i + 15) & 15]
                   + c_reg[(i + 27) & 15];
    endfunction

    // Accepted input word; a sixteenth word absorbs the block.
    function void note_word(logic fin_mode, logic [31:0] w);
      msg_blk[fill] = w;
      if (fill < 15) begin
        fill++;
        return;
      end
      fill = 0;
      for (int i = 0; i < 16; i++) b_reg[i] += msg_blk[i];
      mix_counter();
      permute();
      if (!fin_mode) begin
        for (int i = 0; i < 16; i++) c_reg[i] -= msg_blk[i];
        exchange_bc();
        blk_cnt++;
        return;
      end
      for (int r = 0; r < 3; r++) begin
        exchange_bc();
        mix_counter();
        permute();
      end
      for (int i = 0; i < 8; i++) begin
        dig_q.push_back(b_reg[8 + i]);
        idx_q.push_back(3'(i));
        last_q.push_back(i == 7);
      end
      init_state();
    endfunction

    function void check_digest(logic [31:0] d, logic [2:0] ix, logic lst);
      logic [31:0] ed;
      logic [2:0]  ei;
      logic        el;
      if (dig_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h idx %0d", d, ix);
        return;
      end
      ed = dig_q.pop_front();
      ei = idx_q.pop_front();
      el = last_q.pop_front();
      if (d !== ed || ix !== ei || lst !== el) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                   ed, ei, el, d, ix, lst);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [31:0] in_message_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  always #5 clk = ~clk;

  shabal256_hash_core i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_message_word,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );

  digest_scoreboard sb = new();
  int unsigned send_idle_pct = 0;  // chance per cycle the sender holds off
  int unsigned recv_stall_pct = 0; // chance per cycle the receiver stalls
  int unsigned quiet_cycles = 0;

  // Receiver side: random stall, check every accepted digest word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_digest(out_digest_word, out_word_index, out_last_word);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("shabal256_hash_core test failed");
        $finish;
      end
    end
  end

  // Offer one word and hold it until accepted; random idle gaps before it.
  // Valid stays high after acceptance unless an idle gap or drain follows.
  task automatic send_word(logic m, logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_message_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(m, w);
  endtask

  // One block; only the mode of the sixteenth word decides its kind.
  // kind: 0 random words, 1 all zero, 2 all ones, 3 one random bit set.
  task automatic send_block(logic fin, int kind, bit mixed);
    logic [31:0] w;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        1: begin
          w = '0;
        end
        2: begin
          w = '1;
        end
        3: begin
          w = 32'h1 << ($urandom_range(31));
        end
        default: begin
          w = $urandom;
        end
      endcase
      send_word((i == 15) ? fin : (mixed ? 1'($urandom) : fin), w);
    end
  endtask

  // A message: nblk ordinary blocks (possibly none) then a final block.
  task automatic send_message(int nblk);
    for (int b = 0; b < nblk; b++) send_block(1'b0, 0, 1'($urandom_range(1)));
    send_block(1'b1, 0, 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.dig_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero and all-ones words, a single random bit, both modes, mixed
    // modes inside a block, and a final block straight after reset.
    send_block(1'b1, 1, 1'b0);
    send_block(1'b0, 2, 1'b1);
    send_block(1'b1, 3, 1'b1);
    drain();

    // Random messages, one per idling phase pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      send_message((ph == 3) ? 1 : 0);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    if (sb.mismatches == 0 && sb.dig_q.size() == 0) begin
      $display("shabal256_hash_core test passed");
    end else begin
      $display("shabal256_hash_core test failed");
    end
    $finish;
  end
endmodule
